// File: src/skix_pkg.sv
// Shared constants, codes and types of the sorted key index.
`default_nettype none
package skix_pkg;

    localparam int CAPACITY = 1024;
    localparam int BUCKETS  = 128;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY) + 1;
    localparam int POS_W    = 10;
    localparam int BKT_W    = 7;
    localparam int STAT_W   = 3;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] record_key;
        logic [BKT_W-1:0] course_code;
        logic [BKT_W-1:0] region_code;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  prev_course_head;
        logic              prev_course_valid;
        logic [POS_W-1:0]  prev_region_head;
        logic              prev_region_valid;
    } t_res;

    typedef struct packed {
        logic             load;
        logic             srch_issue;
        logic             srch_step;
        logic             shift_init;
        logic             shift;
        logic             ins;
        logic             res_set;
        logic [STAT_W-1:0] res_code;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic lookup;
        logic lo_lt_hi;
        logic key_eq;
        logic full;
        logic shift_more;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: src/sorted_key_index_with_bucket_heads.sv
// Top level of the sorted key index with course and region bucket heads.
`default_nettype none
// Keeps up to 1024 keys sorted ascending in one single-port-read, single-port-write
// memory, each with its arrival position, plus a head register file for 128 course
// and 128 region buckets. One item is handled at a time. Every item starts with a
// binary search whose steps each read the middle entry, then compare. An insert that
// is not rejected then shifts every entry above the insertion slot up by one, one
// entry per cycle through the memory's read and write ports, and writes the new
// entry. The next item is taken while a result still waits in the output register.
// No clearing pass is needed after reset.
module sorted_key_index_with_bucket_heads (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire skix_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output skix_pkg::t_res      o_out_data
);

    skix_pkg::t_cmd cmd;
    skix_pkg::t_sts sts;

    skix_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skix_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while an item is in work");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.srch_issue, cmd.srch_step, cmd.shift_init,
                  cmd.shift, cmd.ins, cmd.out_load}))
        else $error("more than one datapath action in a cycle");

    a_no_insert_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins |-> !sts.full)
        else $error("insert into a full table");

    a_result_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an item not yet taken");

endmodule
`default_nettype wire

// File: src/skix_ctrl.sv
// Controller state machine of the sorted key index.
`default_nettype none
module skix_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire skix_pkg::t_sts i_sts,
    output skix_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SADDR = 3'd1;
    localparam logic [2:0] S_SCMP  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SADDR;
                end
            end
            S_SADDR: begin
                if (i_sts.lo_lt_hi) begin
                    o_cmd.srch_issue = 1'b1;
                    n_state          = S_SCMP;
                end else if (i_sts.lookup) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = skix_pkg::ST_NOT_FOUND;
                    n_state        = S_RESP;
                end else if (i_sts.full) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = skix_pkg::ST_FULL;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end
            end
            S_SCMP: begin
                if (i_sts.key_eq) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = i_sts.lookup ? skix_pkg::ST_FOUND
                                                  : skix_pkg::ST_DUPLICATE;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.srch_step = 1'b1;
                    n_state         = S_SADDR;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (!i_sts.shift_more) begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_cmd.ins      = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_code = skix_pkg::ST_INSERTED;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/skix_dp.sv
// Datapath of the sorted key index: entry memory, bucket heads, search and result.
`default_nettype none
module skix_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire skix_pkg::t_req i_in_data,
    input  wire skix_pkg::t_cmd i_cmd,
    output skix_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output skix_pkg::t_res      o_out_data
);

    typedef struct packed {
        logic [skix_pkg::KEY_W-1:0] key;
        logic [skix_pkg::POS_W-1:0] pos;
    } t_ent;

    localparam int CNT_W  = skix_pkg::CNT_W;
    localparam int ADDR_W = skix_pkg::ADDR_W;
    localparam int POS_W  = skix_pkg::POS_W;

    t_ent                       mem [skix_pkg::CAPACITY];
    logic [POS_W-1:0]           course_mem [skix_pkg::BUCKETS];
    logic [POS_W-1:0]           region_mem [skix_pkg::BUCKETS];
    logic [skix_pkg::BUCKETS-1:0] r_cvld;
    logic [skix_pkg::BUCKETS-1:0] r_rvld;

    skix_pkg::t_req   r_req;
    skix_pkg::t_res   r_res;
    skix_pkg::t_res   n_res;
    skix_pkg::t_res   r_out;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_hi;
    logic [CNT_W-1:0] r_mid;
    logic [CNT_W-1:0] r_k;
    logic             r_pend;
    logic [ADDR_W-1:0] r_pend_addr;
    t_ent             r_rd;
    logic [POS_W-1:0] r_ch_rd;
    logic [POS_W-1:0] r_rh_rd;

    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  k_m1;
    logic              shift_more;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_ent              wr_data;

    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid        = mid_sum[CNT_W:1];
    assign k_m1       = r_k - CNT_W'(1);
    assign shift_more = (r_k > r_lo);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = mid[ADDR_W-1:0];
        if (i_cmd.srch_issue) begin
            rd_en = 1'b1;
        end else if (i_cmd.shift && shift_more) begin
            rd_en   = 1'b1;
            rd_addr = k_m1[ADDR_W-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pend_addr;
        wr_data = r_rd;
        if (i_cmd.ins) begin
            wr_en       = 1'b1;
            wr_addr     = r_lo[ADDR_W-1:0];
            wr_data.key = r_req.record_key;
            wr_data.pos = r_count[POS_W-1:0];
        end else if (i_cmd.shift && r_pend) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Bucket heads: read at the held codes, swap in the new position on insert.
    always_ff @(posedge i_clk) begin
        r_ch_rd <= course_mem[r_req.course_code];
        r_rh_rd <= region_mem[r_req.region_code];
        if (i_cmd.ins) begin
            course_mem[r_req.course_code] <= r_count[POS_W-1:0];
            region_mem[r_req.region_code] <= r_count[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
            r_rvld <= '0;
        end else if (i_cmd.ins) begin
            r_cvld[r_req.course_code] <= 1'b1;
            r_rvld[r_req.region_code] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.ins) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.shift_init) begin
                r_pend <= 1'b0;
            end else if (i_cmd.shift) begin
                r_pend <= shift_more;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_data;
            r_lo  <= '0;
            r_hi  <= r_count;
        end
        if (i_cmd.srch_issue) begin
            r_mid <= mid;
        end
        if (i_cmd.srch_step) begin
            if (r_rd.key < r_req.record_key) begin
                r_lo <= r_mid + CNT_W'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.shift_init) begin
            r_k <= r_count;
        end else if (i_cmd.shift && shift_more) begin
            r_k         <= k_m1;
            r_pend_addr <= r_k[ADDR_W-1:0];
        end
    end

    always_comb begin
        n_res        = '0;
        n_res.status = i_cmd.res_code;
        if (i_cmd.res_code == skix_pkg::ST_FOUND) begin
            n_res.position = r_rd.pos;
        end
        if (i_cmd.res_code == skix_pkg::ST_INSERTED) begin
            n_res.position          = r_count[POS_W-1:0];
            n_res.prev_course_valid = r_cvld[r_req.course_code];
            n_res.prev_region_valid = r_rvld[r_req.region_code];
            n_res.prev_course_head  = r_cvld[r_req.course_code] ? r_ch_rd : '0;
            n_res.prev_region_head  = r_rvld[r_req.region_code] ? r_rh_rd : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // Output register: hold the item until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.lookup     = r_req.req_type;
        o_sts.lo_lt_hi   = (r_lo < r_hi);
        o_sts.key_eq     = (r_rd.key == r_req.record_key);
        o_sts.full       = (r_count >= CNT_W'(skix_pkg::CAPACITY));
        o_sts.shift_more = shift_more;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

endmodule
`default_nettype wire
